>>> design/spectral_peak_drift_detector_macros.svh
// Assertion macros for the spectral peak drift detector.
// Included by the top-level module to check its own logic; no other dependencies.
`ifndef SPECTRAL_PEAK_DRIFT_DETECTOR_MACROS_SVH
`define SPECTRAL_PEAK_DRIFT_DETECTOR_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define SPDD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("spdd check failed");
// Expression must never be true outside reset.
`define SPDD_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("spdd forbidden condition");
`else
`define SPDD_ASSERT(lbl, clk, rstn, prop)
`define SPDD_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> design/spdd_pkg.sv
// Shared types and constants of the spectral peak drift detector.
// No dependencies.
package spdd_pkg;

	// Request kinds carried on tuser.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TABLE  = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_HALFWIDTH = 2'd2;

	// Search modes.
	localparam logic [1:0] MODE_FULL  = 2'd0;
	localparam logic [1:0] MODE_ALARM = 2'd1;
	localparam logic [1:0] MODE_SCORE = 2'd2;
	localparam logic [1:0] MODE_STEP  = 2'd3;

	// Register widths and reset values.
	localparam int THR_W  = 14;
	localparam int HW_W   = 9;
	localparam int CFG_W  = 14;
	localparam logic [THR_W-1:0] THR_RESET = 14'd1536;
	localparam logic [HW_W-1:0]  HW_RESET  = 9'd15;

	// Field widths.
	localparam int PWR_W    = 16;
	localparam int TIDX_W   = 4;
	localparam int TBIN_W   = 13;
	localparam int PBIN_W   = 10;
	localparam int EXC_W    = 16;
	localparam int SCORE_W  = 9;
	localparam int SCORE_Q_W = 7;
	localparam int TABLE_DEPTH = 16;
	localparam int WIN_W    = 15;

	// Drift scoring constants.
	localparam logic [SCORE_W-1:0] SCORE_LIMIT   = 9'd100;
	localparam logic [SCORE_W-1:0] NO_PEAK_STEP  = 9'd10;
	localparam logic [SCORE_W-1:0] MOVE_STEP     = 9'd1;

	// Running extreme reset values.
	localparam logic signed [PWR_W-1:0] PWR_MOST_POS = 16'sh7FFF;
	localparam logic signed [PWR_W-1:0] PWR_MOST_NEG = 16'sh8000;

	// One result item.
	typedef struct packed {
		logic                  in_band;
		logic [TIDX_W-1:0]     target_index;
		logic [SCORE_W-1:0]    score_value;
		logic [EXC_W-1:0]      excess_db;
		logic [PBIN_W-1:0]     peak_bin;
		logic                  falling_peak;
		logic                  peak_found;
	} result_t;

endpackage

>>> design/spdd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module spdd_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/spectral_peak_drift_detector.sv
// Channel   Dir  Content (lowest bit first)
// s_*       in   tuser cmd; tlast last_bin; tdata power_db, table_index, table_bin
// m_*       out  tdata peak_found, falling_peak, peak_bin, excess_db, score_value,
//                target_index, in_band
// cfg_*     in   write enable, register index, write data
//
// One request per cycle; each passes through the working stage and a frame
// result then sits in the output register until taken. The target table RAM is
// read as each request enters, so the window is ready when bin 0 is processed.
// Reset clears all control state at once; the table holds garbage until loaded.
// s_tready falls only while a frame-end request waits behind a full output register.
//
// Top level of the spectral peak drift detector.
// Depends on spdd_pkg, spdd_ram and spectral_peak_drift_detector_macros.svh.
`include "spectral_peak_drift_detector_macros.svh"

module spectral_peak_drift_detector #(
	parameter int BINS        = 1024,
	parameter int LAST_TARGET = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // power_db[15:0], table_index[19:16], table_bin[32:20]
	input  logic        s_tuser,  // cmd
	input  logic        s_tlast,  // last_bin
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // peak_found[0], falling_peak[1], peak_bin[11:2],
	                              // excess_db[27:12], score_value[36:28],
	                              // target_index[40:37], in_band[41]
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	localparam int CW = $clog2(BINS);
	localparam logic [CW-1:0] BIN_TOP = CW'(BINS - 1);
	localparam logic signed [spdd_pkg::WIN_W-1:0] WIN_TOP = spdd_pkg::WIN_W'(BINS - 1);
	localparam logic signed [spdd_pkg::WIN_W-1:0] WIN_ONE = 15'sd1;
	localparam logic [spdd_pkg::TIDX_W:0] TGT_LAST = 5'(LAST_TARGET);

	// Configuration registers.
	logic [1:0]                  mode_q;
	logic [spdd_pkg::THR_W-1:0]  thr_q;
	logic [spdd_pkg::HW_W-1:0]   hw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= spdd_pkg::MODE_FULL;
			thr_q  <= spdd_pkg::THR_RESET;
			hw_q   <= spdd_pkg::HW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spdd_pkg::REG_MODE:      mode_q <= cfg_data[1:0];
				spdd_pkg::REG_THRESHOLD: thr_q  <= cfg_data[spdd_pkg::THR_W-1:0];
				spdd_pkg::REG_HALFWIDTH: hw_q   <= cfg_data[spdd_pkg::HW_W-1:0];
				default: ;
			endcase
		end
	end

	// Working stage and handshake.
	logic                               valid_s1;
	logic                               cmd_s1;
	logic                               last_s1;
	logic signed [spdd_pkg::PWR_W-1:0]  power_s1;
	logic                               go_s1;
	logic                               emit_s1;
	logic                               accept;

	assign go_s1   = valid_s1 && (cmd_s1 == spdd_pkg::CMD_TABLE || !last_s1 ||
	                              !m_tvalid || m_tready);
	assign emit_s1 = go_s1 && cmd_s1 == spdd_pkg::CMD_SAMPLE && last_s1;
	assign s_tready = !valid_s1 || go_s1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= s_tuser;
			last_s1  <= s_tlast;
			power_s1 <= signed'(s_tdata[15:0]);
		end
	end

	// Frame state.
	logic [CW-1:0]                      bin_cnt_q;
	logic [CW-1:0]                      win_low_q;
	logic [CW-1:0]                      win_high_q;
	logic signed [spdd_pkg::PWR_W-1:0]  run_min_q;
	logic signed [spdd_pkg::PWR_W-1:0]  run_max_q;
	logic [CW-1:0]                      max_bin_q;
	logic [CW-1:0]                      prev_peak_q;
	logic [spdd_pkg::SCORE_Q_W-1:0]     score_q;
	logic [spdd_pkg::TIDX_W-1:0]        target_q;

	// Target table: written as a load request enters, read at the target
	// slot that will hold once the working stage has finished this cycle.
	logic [spdd_pkg::TIDX_W-1:0]  target_d;
	logic [spdd_pkg::TBIN_W-1:0]  tbin_rd;

	spdd_ram #(
		.WIDTH(spdd_pkg::TBIN_W),
		.DEPTH(spdd_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (accept && s_tuser == spdd_pkg::CMD_TABLE),
		.waddr(s_tdata[19:16]),
		.wdata(s_tdata[32:20]),
		.re   (accept),
		.raddr(target_d),
		.rdata(tbin_rd)
	);

	// Window from the target centre, clamped into the band (the whole band in full mode).
	logic signed [spdd_pkg::WIN_W-1:0] tgt_c, hw_c, lo_c, hi_c;
	logic [CW-1:0]                     win_low_c, win_high_c;
	logic                              first_bin;

	assign first_bin = bin_cnt_q == '0;

	always_comb begin
		tgt_c = {{(spdd_pkg::WIN_W - spdd_pkg::TBIN_W){tbin_rd[spdd_pkg::TBIN_W-1]}},
		         tbin_rd};
		hw_c  = signed'({{(spdd_pkg::WIN_W - spdd_pkg::HW_W){1'b0}}, hw_q});
		lo_c  = tgt_c - hw_c;
		hi_c  = tgt_c + hw_c;
		if (lo_c < WIN_ONE) begin
			lo_c = WIN_ONE;
		end
		if (hi_c < lo_c) begin
			hi_c = lo_c + WIN_ONE;
		end
		if (hi_c > WIN_TOP) begin
			hi_c = WIN_TOP;
		end
		if (lo_c > hi_c) begin
			lo_c = hi_c - WIN_ONE;
		end
		if (!first_bin) begin
			win_low_c  = win_low_q;
			win_high_c = win_high_q;
		end else if (mode_q == spdd_pkg::MODE_FULL) begin
			win_low_c  = CW'(1);
			win_high_c = BIN_TOP;
		end else begin
			win_low_c  = CW'(lo_c);
			win_high_c = CW'(hi_c);
		end
	end

	// Running extremes; bin 0 is never inside a window.
	logic                               in_win;
	logic signed [spdd_pkg::PWR_W-1:0]  min_n, max_n;
	logic [CW-1:0]                      max_bin_n;

	always_comb begin
		in_win    = !first_bin && bin_cnt_q >= win_low_q && bin_cnt_q < win_high_q;
		min_n     = run_min_q;
		max_n     = run_max_q;
		max_bin_n = max_bin_q;
		if (in_win && power_s1 < run_min_q) begin
			min_n = power_s1;
		end
		if (in_win && power_s1 > run_max_q) begin
			max_n     = power_s1;
			max_bin_n = bin_cnt_q;
		end
	end

	// Frame-end decision and drift score.
	logic signed [spdd_pkg::PWR_W:0]    diff_c, thr_c;
	logic                               peak_c, fall_c;
	logic [spdd_pkg::SCORE_W-1:0]       score_c;
	logic [spdd_pkg::TIDX_W:0]          tgt_step;
	logic [spdd_pkg::TIDX_W-1:0]        target_end;
	logic [CW:0]                        mb_ext, pp_ext;

	always_comb begin
		diff_c   = {max_n[spdd_pkg::PWR_W-1], max_n} - {min_n[spdd_pkg::PWR_W-1], min_n};
		thr_c    = signed'({{(spdd_pkg::PWR_W + 1 - spdd_pkg::THR_W){1'b0}}, thr_q});
		mb_ext   = {1'b0, max_bin_n};
		pp_ext   = {1'b0, prev_peak_q};
		score_c  = {{(spdd_pkg::SCORE_W - spdd_pkg::SCORE_Q_W){1'b0}}, score_q};
		peak_c   = 1'b0;
		fall_c   = 1'b0;
		if (mode_q != spdd_pkg::MODE_FULL) begin
			if (diff_c > thr_c) begin
				peak_c = 1'b1;
				if (mode_q == spdd_pkg::MODE_SCORE || mode_q == spdd_pkg::MODE_STEP) begin
					if (mb_ext + 1'b1 == pp_ext) begin
						score_c = score_c >> 1;
						fall_c  = 1'b1;
					end else if (mb_ext == pp_ext + 1'b1) begin
						score_c = score_c + (score_c << 1);
					end else begin
						score_c = score_c + spdd_pkg::MOVE_STEP;
					end
				end
			end else begin
				score_c = score_c + spdd_pkg::NO_PEAK_STEP;
			end
		end
		target_end = target_q;
		tgt_step   = {1'b0, target_q} + 1'b1;
		if (score_c > spdd_pkg::SCORE_LIMIT) begin
			score_c = '0;
			if (mode_q == spdd_pkg::MODE_STEP) begin
				target_end = (tgt_step > TGT_LAST) ? spdd_pkg::TIDX_W'(1)
				                                   : tgt_step[spdd_pkg::TIDX_W-1:0];
			end
		end
		target_d = (emit_s1) ? target_end : target_q;
	end

	// State update as the working stage completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q   <= '0;
			win_low_q   <= CW'(1);
			win_high_q  <= BIN_TOP;
			run_min_q   <= spdd_pkg::PWR_MOST_POS;
			run_max_q   <= spdd_pkg::PWR_MOST_NEG;
			max_bin_q   <= '0;
			prev_peak_q <= '0;
			score_q     <= '0;
			target_q    <= spdd_pkg::TIDX_W'(1);
		end else if (go_s1 && cmd_s1 == spdd_pkg::CMD_SAMPLE) begin
			win_low_q  <= win_low_c;
			win_high_q <= win_high_c;
			if (last_s1) begin
				bin_cnt_q <= '0;
				run_min_q <= spdd_pkg::PWR_MOST_POS;
				run_max_q <= spdd_pkg::PWR_MOST_NEG;
				max_bin_q <= '0;
				score_q   <= score_c[spdd_pkg::SCORE_Q_W-1:0];
				target_q  <= target_end;
				if (peak_c && (mode_q == spdd_pkg::MODE_SCORE ||
				               mode_q == spdd_pkg::MODE_STEP)) begin
					prev_peak_q <= max_bin_n;
				end
			end else begin
				if (bin_cnt_q < BIN_TOP) begin
					bin_cnt_q <= bin_cnt_q + 1'b1;
				end
				run_min_q <= min_n;
				run_max_q <= max_n;
				max_bin_q <= max_bin_n;
			end
		end
	end

	// Output register.
	logic                 out_valid_q;
	spdd_pkg::result_t    out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_s1) begin
			out_q.peak_found   <= peak_c;
			out_q.falling_peak <= fall_c;
			out_q.peak_bin     <= spdd_pkg::PBIN_W'(max_bin_n);
			out_q.excess_db    <= (diff_c > 0) ? diff_c[spdd_pkg::EXC_W-1:0] : '0;
			out_q.score_value  <= score_c;
			out_q.target_index <= target_end;
			out_q.in_band      <= {1'b0, win_high_c} > ({1'b0, win_low_c} + 1'b1);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q};

	// Checks on the frame state and the result path.
	`SPDD_ASSERT(a_win_order, clk, arst_n, win_low_q <= win_high_q && win_high_q <= BIN_TOP)
	`SPDD_ASSERT(a_score_range, clk, arst_n, score_q <= spdd_pkg::SCORE_Q_W'(100))
	`SPDD_NEVER(a_target_nonzero, clk, arst_n, target_q == '0)
	`SPDD_ASSERT(a_emit_shows, clk, arst_n, emit_s1 |=> m_tvalid)
	`SPDD_NEVER(a_no_overwrite, clk, arst_n, emit_s1 && m_tvalid && !m_tready)

endmodule
